/* design/quadtree_buddy_allocator_core_defines.svh */
// assertion macros for the quadtree buddy allocator checker
// expects clk and rst in the scope of each use
`ifndef QUADTREE_BUDDY_ALLOCATOR_CORE_DEFINES_SVH
`define QUADTREE_BUDDY_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define QTBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QTBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/qtba_pkg.sv */
// shared constants, codes and request/response types for the quadtree buddy allocator
// no dependencies
package qtba_pkg;

  localparam int ATLAS_SIZE_DEF  = 512;
  localparam int LEVEL_COUNT_DEF = 5;
  localparam int TILE_SIDE       = 256;

  localparam logic [1:0] OP_RESERVE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_LEVEL = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] level;
    logic [8:0] block_x;
    logic [8:0] block_y;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  out_x;
    logic [8:0]  out_y;
    logic [18:0] free_texels;
    logic [2:0]  free_tiles;
  } rsp_t;

endpackage

/* design/quadtree_buddy_allocator_core.sv */
// quadtree buddy allocator: one request at a time, result held in an output register
// reserve pops a free block and splits it down to the asked level; query and rejected
// requests go straight to the result; release probes its own block, ancestors and all
// descendants, then per merge level checks each quadrant and buddy and walks the free
// lists, then pushes buddies back and finishes; the next request is taken the cycle after
// the result moves out; after reset a clearing pass over all nodes runs before any request
module quadtree_buddy_allocator_core import qtba_pkg::*; #(
  parameter int ATLAS_SIZE  = ATLAS_SIZE_DEF,
  parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [3:0]  level,
  input  logic [8:0]  block_x,
  input  logic [8:0]  block_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [8:0]  out_x,
  output logic [8:0]  out_y,
  output logic [18:0] free_texels,
  output logic [2:0]  free_tiles
);

  req_t req;
  rsp_t rsp;
  logic eng_idle, eng_done, take;

  assign req.operation = operation;
  assign req.level     = level;
  assign req.block_x   = block_x;
  assign req.block_y   = block_y;

  assign in_stall = !eng_idle;
  // the output register frees when empty or when its result is taken this cycle
  assign take     = eng_done && (!out_valid || !out_stall);

  qtba_engine #(.ATLAS_SIZE(ATLAS_SIZE), .LEVEL_COUNT(LEVEL_COUNT)) u_engine (
    .clk(clk), .rst(rst), .start(in_valid && eng_idle), .req(req),
    .idle(eng_idle), .done(eng_done), .take(take), .rsp(rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status      <= rsp.status;
      out_x       <= rsp.out_x;
      out_y       <= rsp.out_y;
      free_texels <= rsp.free_texels;
      free_tiles  <= rsp.free_tiles;
    end
  end

endmodule

/* design/qtba_ram.sv */
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module qtba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/qtba_engine.sv */
// allocator sequencer: free-list heads, counters, link and free-flag rams
// depends on qtba_pkg and qtba_ram
module qtba_engine import qtba_pkg::*; #(
  parameter int ATLAS_SIZE  = ATLAS_SIZE_DEF,
  parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic idle,
  output logic done,
  input  logic take,
  output rsp_t rsp
);

  localparam int TPR        = ATLAS_SIZE / TILE_SIDE;
  localparam int TILE_COUNT = TPR * TPR;
  localparam int TSH        = $clog2(TPR);
  localparam int NODE_COUNT = TILE_COUNT * (((1 << (2 * LEVEL_COUNT)) - 1) / 3);
  localparam int NW         = $clog2(NODE_COUNT + 1);
  localparam int AW         = $clog2(NODE_COUNT);
  localparam int CW         = $clog2(ATLAS_SIZE);
  localparam int TXW        = $clog2(ATLAS_SIZE * ATLAS_SIZE + 1);
  localparam int TCW        = $clog2(TILE_COUNT + 1);
  localparam int LIW        = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int SPW        = (LEVEL_COUNT > 1) ? LEVEL_COUNT - 1 : 1;
  localparam logic [NW-1:0] NO_NODE = NW'(NODE_COUNT);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_POP      = 4'd2;
  localparam logic [3:0] S_POPW     = 4'd3;
  localparam logic [3:0] S_SPLIT    = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_CHK = 4'd6;
  localparam logic [3:0] S_MERGE_Q  = 4'd7;
  localparam logic [3:0] S_UL_CHK   = 4'd8;
  localparam logic [3:0] S_WALK_RD  = 4'd9;
  localparam logic [3:0] S_WALK_CHK = 4'd10;
  localparam logic [3:0] S_BUD      = 4'd11;
  localparam logic [3:0] S_FINAL    = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  function automatic logic [NW-1:0] node_at(input logic [NW-1:0] base,
                                            input logic [LIW-1:0] l,
                                            input logic [CW-1:0] x,
                                            input logic [CW-1:0] y);
    return base + (NW'(y) << (TSH + int'(l))) + NW'(x);
  endfunction

  function automatic logic [TXW-1:0] area(input logic [LIW-1:0] l);
    return TXW'(1) << (16 - 2 * int'(l));
  endfunction

  logic [NW-1:0] base_tab [LEVEL_COUNT];
  for (genvar g = 0; g < LEVEL_COUNT; g++) begin : g_base
    assign base_tab[g] = NW'(TILE_COUNT * (((1 << (2 * g)) - 1) / 3));
  end

  logic [3:0]     state;
  logic [NW-1:0]  head [LEVEL_COUNT];
  logic [TXW-1:0] texel;
  logic [TCW-1:0] tiles;
  logic [NW-1:0]  clr;
  logic [LIW-1:0] lvl, cl, sa;
  logic [CW-1:0]  cx, cy;
  logic [1:0]     sub, found, pi;
  logic [2:0]     q;
  logic [SPW-1:0] si, sj;
  logic [NW-1:0]  link, cur, prev, bnode;
  logic [NW-1:0]  bud [3];
  logic [1:0]     st;
  logic [8:0]     ox, oy;

  // ram ports
  logic          nx_we, fr_we, fr_wd, fr_rd;
  logic [AW-1:0] nx_wa, nx_ra, fr_wa, fr_ra;
  logic [NW-1:0] nx_wd, nx_rd;

  qtba_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd)
  );

  qtba_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_free_ram (
    .clk(clk), .we(fr_we), .waddr(fr_wa), .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd)
  );

  // dispatch helpers
  logic [LIW-1:0] pick_l;
  logic           pick_ok;
  logic [NW-1:0]  hd, loc, nd, scan_nd;
  logic [CW-1:0]  sx, sy, qx, qy, pop_x, pop_y;
  logic [SPW-1:0] span_m1;
  logic           scan_last;

  always_comb begin
    pick_l  = '0;
    pick_ok = 1'b0;
    for (int k = 0; k < LEVEL_COUNT; k++) begin
      if (k <= int'(req.level) && head[k] != NO_NODE) begin
        pick_l  = LIW'(k);
        pick_ok = 1'b1;
      end
    end
  end

  always_comb begin
    hd    = head[cl];
    loc   = hd - base_tab[cl];
    pop_x = CW'(loc & ((NW'(1) << (TSH + int'(cl))) - NW'(1)));
    pop_y = CW'(loc >> (TSH + int'(cl)));
    if (sa <= lvl) begin
      sx        = cx >> (lvl - sa);
      sy        = cy >> (lvl - sa);
      span_m1   = '0;
      scan_last = 1'b1;
    end else begin
      sx        = (cx << (sa - lvl)) | CW'(si);
      sy        = (cy << (sa - lvl)) | CW'(sj);
      span_m1   = SPW'((1 << int'(sa - lvl)) - 1);
      scan_last = (si == span_m1) && (sj == span_m1);
    end
    scan_nd = node_at(base_tab[sa], sa, sx, sy);
    qx      = {cx[CW-1:1], q[0]};
    qy      = {cy[CW-1:1], q[1]};
    case (state)
      S_SPLIT:   nd = node_at(base_tab[cl], cl, cx | CW'(sub[0]), cy | CW'(sub[1]));
      S_MERGE_Q: nd = node_at(base_tab[cl], cl, qx, qy);
      default:   nd = node_at(base_tab[cl], cl, cx, cy);
    endcase
  end

  always_comb begin
    nx_we = 1'b0;
    nx_wa = '0;
    nx_wd = NO_NODE;
    nx_ra = '0;
    fr_we = 1'b0;
    fr_wa = '0;
    fr_wd = 1'b0;
    fr_ra = '0;
    case (state)
      S_CLEAR: begin
        nx_we = 1'b1;
        nx_wa = clr[AW-1:0];
        nx_wd = (clr != '0 && int'(clr) < TILE_COUNT) ? clr - NW'(1) : NO_NODE;
        fr_we = 1'b1;
        fr_wa = clr[AW-1:0];
        fr_wd = int'(clr) < TILE_COUNT;
      end
      S_POP: begin
        nx_ra = hd[AW-1:0];
        fr_we = 1'b1;
        fr_wa = hd[AW-1:0];
      end
      S_SPLIT: begin
        nx_we = 1'b1;
        nx_wa = nd[AW-1:0];
        nx_wd = (sub == 2'd0) ? hd : link;
        fr_we = 1'b1;
        fr_wa = nd[AW-1:0];
        fr_wd = 1'b1;
      end
      S_SCAN_RD: fr_ra = scan_nd[AW-1:0];
      S_MERGE_Q: fr_ra = nd[AW-1:0];
      S_WALK_RD: nx_ra = cur[AW-1:0];
      S_WALK_CHK: begin
        if (cur == bnode) begin
          // unlink: patch predecessor link, head is handled in the register block
          nx_we = prev != NO_NODE;
          nx_wa = prev[AW-1:0];
          nx_wd = nx_rd;
          fr_we = 1'b1;
          fr_wa = bnode[AW-1:0];
        end
      end
      S_BUD: begin
        if (pi != found) begin
          nx_we = 1'b1;
          nx_wa = bud[pi][AW-1:0];
          nx_wd = hd;
          fr_we = 1'b1;
          fr_wa = bud[pi][AW-1:0];
          fr_wd = 1'b1;
        end
      end
      S_FINAL: begin
        nx_we = 1'b1;
        nx_wa = nd[AW-1:0];
        nx_wd = hd;
        fr_we = 1'b1;
        fr_wa = nd[AW-1:0];
        fr_wd = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      texel <= TXW'(ATLAS_SIZE * ATLAS_SIZE);
      tiles <= TCW'(TILE_COUNT);
      for (int k = 0; k < LEVEL_COUNT; k++) begin
        head[k] <= (k == 0) ? NW'(TILE_COUNT - 1) : NO_NODE;
      end
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + NW'(1);
          if (clr == NW'(NODE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            st <= ST_OK;
            ox <= '0;
            oy <= '0;
            sa <= '0;
            si <= '0;
            sj <= '0;
            lvl <= LIW'(req.level);
            cx <= CW'(req.block_x) >> (8 - int'(req.level));
            cy <= CW'(req.block_y) >> (8 - int'(req.level));
            state <= S_DONE;
            if (req.operation == OP_RESERVE) begin
              if (int'(req.level) >= LEVEL_COUNT) begin
                st <= ST_LEVEL;
              end else if (!pick_ok) begin
                st <= ST_FULL;
              end else begin
                cl    <= pick_l;
                state <= S_POP;
              end
            end else if (req.operation == OP_RELEASE) begin
              if (int'(req.level) >= LEVEL_COUNT) begin
                st <= ST_LEVEL;
              end else if (int'(req.block_x) < ATLAS_SIZE && int'(req.block_y) < ATLAS_SIZE) begin
                state <= S_SCAN_RD;
              end
            end
          end
        end
        S_POP: begin
          cx    <= pop_x;
          cy    <= pop_y;
          state <= S_POPW;
        end
        S_POPW: begin
          head[cl] <= nx_rd;
          // net effect of pop plus splits is one block at the asked level
          texel <= texel - area(lvl);
          if (cl == '0) begin
            tiles <= tiles - TCW'(1);
          end
          if (cl == lvl) begin
            ox    <= 9'(cx << (8 - int'(lvl)));
            oy    <= 9'(cy << (8 - int'(lvl)));
            state <= S_DONE;
          end else begin
            cl    <= cl + LIW'(1);
            cx    <= cx << 1;
            cy    <= cy << 1;
            sub   <= '0;
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          link <= nd;
          sub  <= sub + 2'd1;
          if (sub == 2'd2) begin
            // bottom-right quadrant is pushed and popped at once, so it is skipped
            head[cl] <= nd;
            if (cl == lvl) begin
              ox    <= 9'((cx | CW'(1)) << (8 - int'(lvl)));
              oy    <= 9'((cy | CW'(1)) << (8 - int'(lvl)));
              state <= S_DONE;
            end else begin
              cl  <= cl + LIW'(1);
              cx  <= (cx | CW'(1)) << 1;
              cy  <= (cy | CW'(1)) << 1;
              sub <= '0;
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (fr_rd) begin
            state <= S_DONE;
          end else if (scan_last) begin
            si <= '0;
            sj <= '0;
            if (int'(sa) == LEVEL_COUNT - 1) begin
              cl    <= lvl;
              q     <= '0;
              found <= '0;
              state <= S_MERGE_Q;
            end else begin
              sa    <= sa + LIW'(1);
              state <= S_SCAN_RD;
            end
          end else begin
            if (si == span_m1) begin
              si <= '0;
              sj <= sj + SPW'(1);
            end else begin
              si <= si + SPW'(1);
            end
            state <= S_SCAN_RD;
          end
        end
        S_MERGE_Q: begin
          if (cl == '0) begin
            state <= S_FINAL;
          end else if (q == 3'd4) begin
            cl    <= cl - LIW'(1);
            cx    <= cx >> 1;
            cy    <= cy >> 1;
            q     <= '0;
            found <= '0;
          end else if (qx == cx && qy == cy) begin
            q <= q + 3'd1;
          end else begin
            bnode <= nd;
            cur   <= hd;
            prev  <= NO_NODE;
            state <= S_UL_CHK;
          end
        end
        S_UL_CHK: begin
          pi    <= '0;
          state <= fr_rd ? S_WALK_RD : S_BUD;
        end
        S_WALK_RD: begin
          pi    <= '0;
          state <= (cur == NO_NODE) ? S_BUD : S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (cur == bnode) begin
            if (prev == NO_NODE) begin
              head[cl] <= nx_rd;
            end
            texel      <= texel - area(cl);
            bud[found] <= bnode;
            found      <= found + 2'd1;
            q          <= q + 3'd1;
            state      <= S_MERGE_Q;
          end else begin
            prev  <= cur;
            cur   <= nx_rd;
            state <= S_WALK_RD;
          end
        end
        S_BUD: begin
          if (pi == found) begin
            state <= S_FINAL;
          end else begin
            head[cl] <= bud[pi];
            texel    <= texel + area(cl);
            pi       <= pi + 2'd1;
          end
        end
        S_FINAL: begin
          head[cl] <= nd;
          texel    <= texel + area(cl);
          if (cl == '0) begin
            tiles <= tiles + TCW'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle = state == S_IDLE;
  assign done = state == S_DONE;

  always_comb begin
    rsp.status      = st;
    rsp.out_x       = ox;
    rsp.out_y       = oy;
    rsp.free_texels = 19'(texel);
    rsp.free_tiles  = 3'(tiles);
  end

endmodule

/* design/qtba_checker.sv */
// port-level checks for the quadtree buddy allocator, bound to the top level
// depends on qtba_pkg and quadtree_buddy_allocator_core_defines.svh
`include "quadtree_buddy_allocator_core_defines.svh"

module qtba_checker import qtba_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [8:0]  out_x,
  input logic [8:0]  out_y,
  input logic [18:0] free_texels,
  input logic [2:0]  free_tiles
);

  `QTBA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(out_x) && $stable(out_y) && $stable(free_texels) && $stable(free_tiles), "result changed while stalled")

  `QTBA_ASSERT_IMP(a_err_no_coord, out_valid && status != ST_OK, out_x == 9'd0 && out_y == 9'd0, "failed request reports a corner")

  `QTBA_ASSERT_NXT(a_one_request, in_valid && !in_stall, in_stall, "second request taken while one is in work")

endmodule

bind quadtree_buddy_allocator_core qtba_checker u_checker (.*);

/* verif/quadtree_buddy_allocator_core_test.sv */
// testbench for the quadtree buddy allocator core: reserve, release and query requests
// checked against a behavioral allocator model kept in this file; depends on qtba_pkg
module quadtree_buddy_allocator_core_test;
  import qtba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS = LEVEL_COUNT_DEF;
  localparam int TILES_ROW = ATLAS_SIZE_DEF / TILE_SIDE;
  localparam int TILES = TILES_ROW * TILES_ROW;
  localparam int NODES = TILES * (((1 << (2 * LEVELS)) - 1) / 3);
  localparam int NIL = NODES;
  localparam int STALL_LIMIT = 40000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  logic [1:0] operation = 0, status;
  logic [3:0] level = 0;
  logic [8:0] block_x = 0, block_y = 0, out_x, out_y;
  logic [18:0] free_texels;
  logic [2:0] free_tiles;

  quadtree_buddy_allocator_core u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // allocator model state
  int free_head[LEVELS];
  int next_node[NODES];
  bit is_free[NODES];
  int texels_left, tiles_left;
  rsp_t pending_rsp[$];
  int fail_count = 0;
  int idle_pct = 18;
  int idle_cycles = 0;
  // blocks this test holds, for well-formed releases
  int held_lvl[$], held_x[$], held_y[$];

  function automatic int lvl_base(int l);
    int b = 0;
    for (int i = 0; i < l; i++) b += TILES << (2 * i);
    return b;
  endfunction

  function automatic int node_at(int l, int cx, int cy);
    return lvl_base(l) + cy * (TILES_ROW << l) + cx;
  endfunction

  function automatic int area_of(int l);
    return (TILE_SIDE >> l) * (TILE_SIDE >> l);
  endfunction

  function automatic void push_free(int l, int n);
    next_node[n] = free_head[l];
    free_head[l] = n;
    is_free[n] = 1;
    texels_left += area_of(l);
    if (l == 0) tiles_left++;
  endfunction

  function automatic void take(int l, int n);
    is_free[n] = 0;
    texels_left -= area_of(l);
    if (l == 0) tiles_left--;
  endfunction

  function automatic int pop_free(int l);
    int n;
    n = free_head[l];
    if (n >= NIL) return NIL;
    free_head[l] = next_node[n];
    take(l, n);
    return n;
  endfunction

  function automatic bit unlink(int l, int n);
    int prev, cur;
    prev = NIL;
    cur = free_head[l];
    if (!is_free[n]) return 0;
    while (cur < NIL) begin
      if (cur == n) begin
        if (prev == NIL) free_head[l] = next_node[cur];
        else next_node[prev] = next_node[cur];
        take(l, n);
        return 1;
      end
      prev = cur;
      cur = next_node[cur];
    end
    return 0;
  endfunction

  function automatic void split(int l, int n);
    int r, loc, cx, cy;
    r = TILES_ROW << l;
    loc = n - lvl_base(l);
    cx = (loc % r) * 2;
    cy = (loc / r) * 2;
    push_free(l + 1, node_at(l + 1, cx, cy));
    push_free(l + 1, node_at(l + 1, cx + 1, cy));
    push_free(l + 1, node_at(l + 1, cx, cy + 1));
    push_free(l + 1, node_at(l + 1, cx + 1, cy + 1));
  endfunction

  function automatic void reset_allocator();
    for (int i = 0; i < LEVELS; i++) free_head[i] = NIL;
    for (int i = 0; i < NODES; i++) begin
      next_node[i] = NIL;
      is_free[i] = 0;
    end
    texels_left = 0;
    tiles_left = 0;
    for (int i = 0; i < TILES; i++) push_free(0, i);
  endfunction

  function automatic logic [1:0] model_reserve(int lv, output int ox, output int oy);
    int n, r, loc;
    ox = 0;
    oy = 0;
    if (lv >= LEVELS) return ST_LEVEL;
    if (free_head[lv] >= NIL) begin
      for (int k = lv; k > 0; k--) begin
        if (free_head[k - 1] < NIL) begin
          n = pop_free(k - 1);
          for (int c = k - 1; c + 1 < lv; c++) begin
            split(c, n);
            n = pop_free(c + 1);
          end
          split(lv - 1, n);
          break;
        end
      end
    end
    n = pop_free(lv);
    if (n >= NIL) return ST_FULL;
    r = TILES_ROW << lv;
    loc = n - lvl_base(lv);
    ox = (loc % r) << (8 - lv);
    oy = (loc / r) << (8 - lv);
    return ST_OK;
  endfunction

  function automatic bit may_release(int l, int cx, int cy);
    if (is_free[node_at(l, cx, cy)]) return 0;
    for (int a = 0; a < l; a++)
      if (is_free[node_at(a, cx >> (l - a), cy >> (l - a))]) return 0;
    for (int d = l + 1; d < LEVELS; d++) begin
      int k, span;
      k = d - l;
      span = 1 << k;
      for (int j = 0; j < span; j++)
        for (int i = 0; i < span; i++)
          if (is_free[node_at(d, (cx << k) + i, (cy << k) + j)]) return 0;
    end
    return 1;
  endfunction

  function automatic logic [1:0] model_release(int l, int x, int y);
    int cx, cy, found;
    int bud[3];
    if (l >= LEVELS) return ST_LEVEL;
    if (x >= ATLAS_SIZE_DEF || y >= ATLAS_SIZE_DEF) return ST_OK;
    cx = x >> (8 - l);
    cy = y >> (8 - l);
    if (!may_release(l, cx, cy)) return ST_OK;
    while (l > 0) begin
      int px, py;
      px = cx & ~1;
      py = cy & ~1;
      found = 0;
      for (int q = 0; q < 4; q++) begin
        int qx, qy, b;
        qx = px + (q & 1);
        qy = py + (q >> 1);
        if (qx == cx && qy == cy) continue;
        b = node_at(l, qx, qy);
        if (!unlink(l, b)) break;
        bud[found++] = b;
      end
      if (found < 3) begin
        for (int i = 0; i < found; i++) push_free(l, bud[i]);
        break;
      end
      l--;
      cx = px >> 1;
      cy = py >> 1;
    end
    push_free(l, node_at(l, cx, cy));
    return ST_OK;
  endfunction

  task automatic send_request(logic [1:0] op, logic [3:0] lv, logic [8:0] x, logic [8:0] y);
    rsp_t r;
    int ox, oy;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    ox = 0;
    oy = 0;
    r.status = ST_OK;
    if (op == OP_RESERVE) r.status = model_reserve(lv, ox, oy);
    else if (op == OP_RELEASE) r.status = model_release(lv, x, y);
    r.out_x = 9'(ox);
    r.out_y = 9'(oy);
    r.free_texels = 19'(texels_left);
    r.free_tiles = 3'(tiles_left);
    if (op == OP_RESERVE && r.status == ST_OK) begin
      held_lvl.push_back(int'(lv));
      held_x.push_back(ox);
      held_y.push_back(oy);
    end
    pending_rsp.push_back(r);
    in_valid <= 1;
    operation <= op;
    level <= lv;
    block_x <= x;
    block_y <= y;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic release_held(int idx);
    int l, x, y;
    l = held_lvl[idx];
    x = held_x[idx];
    y = held_y[idx];
    held_lvl.delete(idx);
    held_x.delete(idx);
    held_y.delete(idx);
    send_request(OP_RELEASE, 4'(l), 9'(x), 9'(y));
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  // response checking and receiver stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        rsp_t e;
        if (pending_rsp.size() == 0) begin
          $error("response with no request outstanding");
          fail_count++;
        end else begin
          e = pending_rsp.pop_front();
          if (status !== e.status) begin
            $error("status exp %0d got %0d", e.status, status); fail_count++;
          end
          if (out_x !== e.out_x) begin
            $error("out_x exp %0d got %0d", e.out_x, out_x); fail_count++;
          end
          if (out_y !== e.out_y) begin
            $error("out_y exp %0d got %0d", e.out_y, out_y); fail_count++;
          end
          if (free_texels !== e.free_texels) begin
            $error("free_texels exp %0d got %0d", e.free_texels, free_texels);
            fail_count++;
          end
          if (free_tiles !== e.free_tiles) begin
            $error("free_tiles exp %0d got %0d", e.free_tiles, free_tiles); fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_extremes();
    for (int l = 0; l < LEVELS; l++) send_request(OP_RESERVE, 4'(l), 0, 0);
    send_request(OP_RESERVE, 15, 9'h1ff, 9'h1ff);
    send_request(OP_RELEASE, 9, 0, 0);
    send_request(OP_RELEASE, 0, 9'h1ff, 0);
    send_request(OP_RELEASE, 0, 0, 9'h1ff);
    send_request(OP_QUERY, 0, 0, 0);
    send_request(2'd3, 4'hf, 9'h1ff, 9'h1ff);
    // misaligned release of a held block, then a repeated one
    send_request(OP_RELEASE, 4'(held_lvl[1]), 9'(held_x[1] | 'h3f), 9'(held_y[1] | 'h3f));
    send_request(OP_RELEASE, 4'(held_lvl[1]), 9'(held_x[1]), 9'(held_y[1]));
    held_lvl.delete(1); held_x.delete(1); held_y.delete(1);
    while (held_lvl.size() != 0) release_held(held_lvl.size() - 1);
  endtask

  task automatic test_full_atlas();
    // exhaust level 0, then ask the deepest level with nothing to split
    for (int i = 0; i <= TILES; i++) send_request(OP_RESERVE, 0, 0, 0);
    send_request(OP_RESERVE, 4'(LEVELS - 1), 0, 0);
    send_request(OP_RELEASE, 2, 64, 64);
    drain();
    while (held_lvl.size() != 0) release_held(0);
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      int pick;
      pick = $urandom_range(99);
      if (i == count / 3) idle_pct = 0;
      if (i == count / 2) idle_pct = 18;
      if (i == count / 2 + 10) drain();
      if (pick < 50 || held_lvl.size() == 0)
        send_request(OP_RESERVE, 4'($urandom_range(LEVELS - 1)), 9'($urandom), 9'($urandom));
      else if (pick < 85)
        release_held($urandom_range(held_lvl.size() - 1));
      else if (pick < 95)
        send_request(OP_RELEASE, 4'($urandom), 9'($urandom), 9'($urandom));
      else
        send_request(2'($urandom), 4'($urandom), 9'($urandom), 9'($urandom));
    end
  endtask

  initial begin
    reset_allocator();
    repeat (5) @(posedge clk);
    rst <= 0;
    test_extremes();
    test_full_atlas();
    test_random_mix(1500);
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_rsp.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
